// ----- hw/rtl/nlpd_pkg.sv -----
// ============================================================================
// Normalised Lp distance: shared package
// Payload structs, work item passed from the front end to the back end,
// and the state encoding of the back-end sequencer.
// ============================================================================
package nlpd_pkg;

    localparam int unsigned IN_W        = 16;
    localparam int unsigned DIST_W      = 64;
    localparam int unsigned EXP_W       = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [EXP_W-1:0] MAX_EXP   = 3'd4;
    localparam logic [EXP_W-1:0] EXP_RESET = 3'd1;

    typedef struct packed {
        logic [IN_W-1:0] first_value;
        logic [IN_W-1:0] second_value;
        logic            last_element;
    } sample_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } result_t;

    typedef enum logic {
        KIND_SKIP,
        KIND_TERM
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [IN_W-1:0]  diff;
        logic [IN_W:0]    total;
        logic [EXP_W-1:0] power;
        logic             last;
    } work_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POW,
        ST_DIV,
        ST_ADD,
        ST_FINISH,
        ST_ROOT,
        ST_RMUL,
        ST_OUT
    } back_state_t;

endpackage

// ----- hw/rtl/nlpd_front.sv -----
// ============================================================================
// Normalised Lp distance: front end
// Holds the exponent register, clamps each incoming pair, forms the
// difference and sum, and classifies the item for the back end.
// ============================================================================
module nlpd_front
    import nlpd_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  sample_t          sample,
    input  logic             cfg_write,
    input  logic [EXP_W-1:0] cfg_data,
    output logic             item_valid,
    output work_item_t       item,
    input  logic             queue_full
);

    localparam int unsigned CLAMP_BITS = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
    localparam logic [IN_W:0] VMAX_W = ((IN_W+1)'(1) << CLAMP_BITS) - (IN_W+1)'(1);
    localparam logic [IN_W-1:0] VMAX = VMAX_W[IN_W-1:0];

    logic [EXP_W-1:0] power_exponent_reg;
    logic             valid_reg;
    logic             valid_next;
    work_item_t       item_reg;
    work_item_t       item_next;

    logic             accept;
    logic             hand_on;
    logic [IN_W-1:0]  a_clamped;
    logic [IN_W-1:0]  b_clamped;
    logic [EXP_W-1:0] power_eff;

    assign full    = valid_reg && queue_full;
    assign accept  = push && !full;
    assign hand_on = valid_reg && !queue_full;

    assign a_clamped = (sample.first_value > VMAX) ? VMAX : sample.first_value;
    assign b_clamped = (sample.second_value > VMAX) ? VMAX : sample.second_value;
    assign power_eff = (power_exponent_reg > MAX_EXP) ? MAX_EXP : power_exponent_reg;

    always_comb
    begin
        item_next.diff  = (a_clamped > b_clamped) ? (a_clamped - b_clamped)
                                                  : (b_clamped - a_clamped);
        item_next.total = {1'b0, a_clamped} + {1'b0, b_clamped};
        item_next.power = power_eff;
        item_next.last  = sample.last_element;
        // A pair only contributes a term when the exponent is non-zero and
        // the denominator is non-zero; otherwise only the maximum moves.
        if ((power_eff != '0) && (item_next.total != '0))
        begin
            item_next.kind = KIND_TERM;
        end
        else
        begin
            item_next.kind = KIND_SKIP;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (hand_on)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_exponent_reg <= EXP_RESET;
            valid_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                power_exponent_reg <= cfg_data;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = hand_on;
    assign item       = item_reg;

endmodule

// ----- hw/rtl/nlpd_queue.sv -----
// ============================================================================
// Normalised Lp distance: work queue
// Short register queue that decouples the front end from the back end.
// ============================================================================
module nlpd_queue
    import nlpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  work_item_t item_in,
    output logic       full,
    input  logic       pop,
    output logic       valid,
    output work_item_t item_out
);

    localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] DEPTH_C  = COUNT_W'(QUEUE_DEPTH);

    work_item_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == DEPTH_C);
    assign valid    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign item_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ----- hw/rtl/nlpd_mul.sv -----
// ============================================================================
// Normalised Lp distance: shift-add multiplier
// One multiplier bit per cycle; finishes as soon as the remaining
// multiplier bits are all zero.
// ============================================================================
module nlpd_mul
    import nlpd_pkg::*;
#(
    parameter int unsigned PROD_W   = 116,
    parameter int unsigned MPLIER_W = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   mcand,
    input  logic [MPLIER_W-1:0] mplier,
    output logic                done,
    output logic [PROD_W-1:0]   product
);

    logic                run_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [PROD_W-1:0]   mcand_reg;
    logic [MPLIER_W-1:0] mplier_reg;

    assign done    = run_reg && (mplier_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (done)
        begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
        end
        else if (run_reg && !done)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

endmodule

// ----- hw/rtl/nlpd_back.sv -----
// ============================================================================
// Normalised Lp distance: back end
// Sequencer that raises each difference to the exponent, divides by the
// pair sum one quotient bit per cycle, accumulates, and on the last pair
// finds the root bit by bit for p of 2 to 4, then loads the result register.
// ============================================================================
module nlpd_back
    import nlpd_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  work_item_t q_item,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output result_t    result
);

    localparam int unsigned TW    = DIST_W + 3 * FRAC_BITS + 4;
    localparam int unsigned NUM_W = 4 * IN_W + FRAC_BITS;
    localparam int unsigned RB2   = (DIST_W + FRAC_BITS + 1) / 2;
    localparam int unsigned RB3   = (DIST_W + 2 * FRAC_BITS + 2) / 3;
    localparam int unsigned RB4   = (DIST_W + 3 * FRAC_BITS + 3) / 4;
    localparam int unsigned MW    = RB2;
    localparam int unsigned BIT_W = $clog2(MW);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);
    localparam int unsigned REM_W = IN_W + 1;

    back_state_t       state_reg;
    back_state_t       state_next;

    logic [IN_W-1:0]   d_reg, d_next;
    logic [REM_W-1:0]  s_reg, s_next;
    logic [EXP_W-1:0]  p_reg, p_next;
    logic              last_reg, last_next;
    logic [1:0]        k_reg, k_next;
    logic [MW-1:0]     cand_reg, cand_next;
    logic [DIST_W-1:0] r_reg, r_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIST_W-1:0] quo_reg, quo_next;
    logic              qsat_reg, qsat_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIST_W-1:0] sum_reg, sum_next;
    logic [IN_W-1:0]   max_reg, max_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg;

    logic              mul_start;
    logic [TW-1:0]     mul_mcand;
    logic [MW-1:0]     mul_mplier;
    logic              mul_done;
    logic [TW-1:0]     mul_product;

    logic              last_mul;
    logic              out_free;
    logic              out_load;
    logic [MW-1:0]     cand_c;
    logic [TW-1:0]     target;
    logic [REM_W:0]    rem_sh;
    logic [REM_W:0]    rem_diff;
    logic              ge;
    logic [DIST_W-1:0] term;
    logic [DIST_W:0]   sum_ext;
    logic [BIT_W-1:0]  bit_start;

    nlpd_mul #(
        .PROD_W   (TW),
        .MPLIER_W (MW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    assign last_mul = ({1'b0, k_reg} == (p_reg - EXP_W'(1)));
    assign out_free = !out_valid_reg || pop;
    assign out_load = (state_reg == ST_OUT) && out_free;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign cand_c   = r_reg[MW-1:0] | (MW'(1) << bit_reg);

    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, s_reg};
    assign ge       = (rem_sh >= {1'b0, s_reg});
    assign term     = qsat_reg ? '1 : quo_reg;
    assign sum_ext  = {1'b0, sum_reg} + {1'b0, term};

    always_comb
    begin
        case (p_reg)
            3'd2:
            begin
                target    = TW'(sum_reg) << FRAC_BITS;
                bit_start = BIT_W'(RB2 - 1);
            end
            3'd3:
            begin
                target    = TW'(sum_reg) << (2 * FRAC_BITS);
                bit_start = BIT_W'(RB3 - 1);
            end
            default:
            begin
                target    = TW'(sum_reg) << (3 * FRAC_BITS);
                bit_start = BIT_W'(RB4 - 1);
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.kind == KIND_TERM)
                    begin
                        state_next = (q_item.power == EXP_W'(1)) ? ST_DIV : ST_POW;
                    end
                    else if (q_item.last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_POW:
            begin
                if (mul_done && last_mul)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                if ((p_reg == '0) || (p_reg == EXP_W'(1)))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                state_next = ST_RMUL;
            end
            ST_RMUL:
            begin
                if (mul_done && last_mul)
                begin
                    state_next = (bit_reg == '0) ? ST_OUT : ST_ROOT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        d_next     = d_reg;
        s_next     = s_reg;
        p_next     = p_reg;
        last_next  = last_reg;
        k_next     = k_reg;
        cand_next  = cand_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        qsat_next  = qsat_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        max_next   = max_reg;
        ovf_next   = ovf_reg;
        mul_start  = 1'b0;
        mul_mcand  = mul_product;
        mul_mplier = cand_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    d_next    = q_item.diff;
                    s_next    = q_item.total;
                    p_next    = q_item.power;
                    last_next = q_item.last;
                    max_next  = (q_item.diff > max_reg) ? q_item.diff : max_reg;
                    num_next  = NUM_W'(q_item.diff) << FRAC_BITS;
                    rem_next  = '0;
                    quo_next  = '0;
                    qsat_next = 1'b0;
                    cnt_next  = CNT_W'(NUM_W);
                    k_next    = 2'd1;
                    if ((q_item.kind == KIND_TERM) && (q_item.power != EXP_W'(1)))
                    begin
                        mul_start  = 1'b1;
                        mul_mcand  = TW'(q_item.diff);
                        mul_mplier = MW'(q_item.diff);
                    end
                end
            end
            ST_POW:
            begin
                if (mul_done)
                begin
                    if (last_mul)
                    begin
                        num_next = NUM_W'(mul_product[DIST_W-1:0]) << FRAC_BITS;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_mplier = MW'(d_reg);
                        k_next     = k_reg + 2'd1;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                quo_next = {quo_reg[DIST_W-2:0], ge};
                // Quotient bits at weight 2^64 and above only flag saturation.
                if (ge && (cnt_reg > CNT_W'(DIST_W)))
                begin
                    qsat_next = 1'b1;
                end
                num_next = num_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_ADD:
            begin
                if (sum_ext[DIST_W])
                begin
                    sum_next = '1;
                    ovf_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_ext[DIST_W-1:0];
                end
                if (qsat_reg)
                begin
                    ovf_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                bit_next = bit_start;
                if (p_reg == '0)
                begin
                    r_next = DIST_W'(max_reg) << FRAC_BITS;
                end
                else if (p_reg == EXP_W'(1))
                begin
                    r_next = sum_reg;
                end
                else
                begin
                    r_next = '0;
                end
            end
            ST_ROOT:
            begin
                cand_next  = cand_c;
                k_next     = 2'd1;
                mul_start  = 1'b1;
                mul_mcand  = TW'(cand_c);
                mul_mplier = cand_c;
            end
            ST_RMUL:
            begin
                if (mul_done)
                begin
                    if (last_mul)
                    begin
                        if (mul_product <= target)
                        begin
                            r_next = DIST_W'(cand_reg);
                        end
                        if (bit_reg != '0)
                        begin
                            bit_next = bit_reg - BIT_W'(1);
                        end
                    end
                    else
                    begin
                        mul_start = 1'b1;
                        k_next    = k_reg + 2'd1;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    sum_next = '0;
                    max_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            max_reg       <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            bit_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            bit_reg       <= bit_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        s_reg    <= s_next;
        p_reg    <= p_next;
        last_reg <= last_next;
        cand_reg <= cand_next;
        r_reg    <= r_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        qsat_reg <= qsat_next;
        if (out_load)
        begin
            result_reg.distance  <= r_reg;
            result_reg.saturated <= (p_reg != '0) && ovf_reg;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    a_no_mul_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mul_done)
        else $error("multiplier completed while the sequencer was idle");

    a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divider running with an exhausted bit count");

    a_root_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> (r_reg[DIST_W-1:MW] == '0))
        else $error("root estimate outside the search width");

    a_cand_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMUL) |-> (cand_reg != '0))
        else $error("root candidate is zero during the power check");

    a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> ((sum_reg == '0) && (max_reg == '0) && !ovf_reg))
        else $error("accumulators not cleared after a result was loaded");

endmodule

// ----- hw/rtl/normalized_lp_vector_distance.sv -----
// ============================================================================
// Normalised Lp vector distance
// Streams coordinate pairs of two count vectors and returns one distance,
// Chebyshev or the p-th root of the summed |a-b|^p/(a+b) terms, per vector.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-------------------------------------
//   sample   | push / full       | first_value, second_value, last_element
//   result   | pop / empty       | distance (Q48.16), saturated
//   config   | cfg_write         | cfg_data = power_exponent
//
// A pair that adds a term takes (p-1) shift-add multiplications, then the
// bit-serial divider and an accumulate step; other pairs only update the
// running maximum. The final pair of a vector adds the root search: for p
// of 2 to 4, one candidate bit per step, each step setting the bit and then
// running (p-1) multiplications on the shared multiplier. A two-entry queue
// lets the front end keep taking transactions while the back end works.
// Reset is asynchronous and active low; no clearing pass is needed.
// ============================================================================
module normalized_lp_vector_distance
    import nlpd_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 16,
    parameter int unsigned FRAC_BITS  = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  sample_t          sample,
    output logic             empty,
    input  logic             pop,
    output result_t          result,
    input  logic             cfg_write,
    input  logic [EXP_W-1:0] cfg_data
);

    logic       item_valid;
    work_item_t item;
    logic       queue_full;
    logic       q_valid;
    work_item_t q_item;
    logic       q_pop;

    nlpd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .queue_full (queue_full)
    );

    nlpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (item_valid),
        .item_in  (item),
        .full     (queue_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .item_out (q_item)
    );

    nlpd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
